/* hw/rtl/uvs_pkg.sv */
// Shared types and constants for the UV-sphere cell vertex generator.
// No dependencies; every other file in hw/rtl imports this package.
package uvs_pkg;

    localparam int RES_MAX    = 256;
    localparam int RES_W      = 9;
    localparam int REM_W      = 8;
    localparam int DIV_W      = 41;
    localparam int DIV_LANES  = 4;
    localparam int PHASE_W    = 32;
    localparam int Q30_W      = 31;
    localparam int HORNER_N   = 6;
    localparam int RCP_W      = 38;
    localparam int RCP_SHIFT  = 40;

    localparam logic [Q30_W-1:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [Q30_W-1:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [RCP_W-1:0] RCP_156 = RCP_W'(((64'd1 << RCP_SHIFT) + 64'd155) / 64'd156);
    localparam logic [RCP_W-1:0] RCP_110 = RCP_W'(((64'd1 << RCP_SHIFT) + 64'd109) / 64'd110);
    localparam logic [RCP_W-1:0] RCP_72  = RCP_W'(((64'd1 << RCP_SHIFT) + 64'd71) / 64'd72);
    localparam logic [RCP_W-1:0] RCP_42  = RCP_W'(((64'd1 << RCP_SHIFT) + 64'd41) / 64'd42);
    localparam logic [RCP_W-1:0] RCP_20  = RCP_W'(((64'd1 << RCP_SHIFT) + 64'd19) / 64'd20);
    localparam logic [RCP_W-1:0] RCP_6   = RCP_W'(((64'd1 << RCP_SHIFT) + 64'd5) / 64'd6);

    localparam logic [RCP_W-1:0] HORNER_RCP [HORNER_N] =
        '{RCP_156, RCP_110, RCP_72, RCP_42, RCP_20, RCP_6};

    typedef struct packed {
        logic                              valid;
        logic                              last;
        logic [DIV_LANES-1:0][DIV_W-1:0]   word;
        logic [DIV_LANES-1:0][REM_W-1:0]   rem;
    } div_stage_t;

endpackage

/* hw/rtl/uv_sphere_cell_vertex_generator.sv */
// Top level of the UV-sphere cell vertex generator: cell sequencer, divider
// chain, sine lanes, coordinate stages and APB registers. Depends on uvs_pkg.
//
//  channel   signals                                         direction
//  in        in_valid, in_stall, lon_index, lat_index         cells in
//  out       out_valid, out_stall, pos_x/y/z, tex_u/v, last   vertices out
//  cfg       psel, penable, pwrite, paddr, pwdata, prdata     APB registers
//
// Each cell yields six vertices; one vertex per cycle leaves the 41-cell divider
// chain while the output is not stalled.
// Reset loads radius 1.0 and resolution 16 and empties the pipeline.
// A stalled output holds the whole pipeline and the cell sequencer.
module uv_sphere_cell_vertex_generator
    import uvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  lon_index,
    input  logic [7:0]  lat_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] pos_x,
    output logic [16:0] pos_y,
    output logic [16:0] pos_z,
    output logic [15:0] tex_u,
    output logic [15:0] tex_v,
    output logic        last_vertex,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int          SINE_LAT  = 15;
    localparam logic [2:0]  K_LAST    = 3'd5;
    localparam logic [5:0]  DA_MASK   = 6'b110010;
    localparam logic [5:0]  DB_MASK   = 6'b101100;
    localparam logic        ADDR_RAD  = 1'b0;
    localparam logic        ADDR_RES  = 1'b1;
    localparam int          L_COSLON  = 0;
    localparam int          L_SINLON  = 1;
    localparam int          L_COSLAT  = 2;
    localparam int          L_SINLAT  = 3;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [15:0]          tex_u;
        logic [15:0]          tex_v;
        logic [DIV_LANES-1:0] neg;
    } side_t;

    logic [15:0]      radius_reg;
    logic [RES_W-1:0] grid_reg;
    logic [RES_W-1:0] res_eff;
    logic             cfg_wr;
    logic             en;
    logic             accept;

    logic             item_valid_reg;
    logic [2:0]       k_reg;
    logic [7:0]       i_reg;
    logic [7:0]       j_reg;
    logic [7:0]       i_next;
    logic [7:0]       j_next;

    logic [RES_W-1:0] corner_a;
    logic [RES_W-1:0] corner_b;
    logic [7:0]       half_res;
    div_stage_t       div_chain [DIV_W+1];

    logic [Q30_W:0]   fold [DIV_LANES];
    side_t            prep_reg;
    logic [Q30_W-1:0] arg_reg [DIV_LANES];
    logic [Q30_W-1:0] sine    [DIV_LANES];
    side_t            side_reg [SINE_LAT];

    side_t            p_side_reg;
    logic [Q30_W-1:0] mx_reg;
    logic [Q30_W-1:0] my_reg;
    logic [Q30_W-1:0] mz_reg;
    logic [61:0]      mx_prod;
    logic [61:0]      my_prod;

    side_t            c_side_reg;
    logic [16:0]      vx_reg;
    logic [16:0]      vy_reg;
    logic [16:0]      vz_reg;
    logic [46:0]      vx_prod;
    logic [46:0]      vy_prod;
    logic [46:0]      vz_prod;

    logic             out_valid_reg;
    logic [16:0]      pos_x_reg;
    logic [16:0]      pos_y_reg;
    logic [16:0]      pos_z_reg;
    logic [15:0]      tex_u_reg;
    logic [15:0]      tex_v_reg;
    logic             last_reg;

    function automatic logic [Q30_W:0] fold_phase(input logic [PHASE_W-1:0] p);
        logic [Q30_W-1:0] f;
        f = {1'b0, p[29:0]};
        fold_phase = {p[31], (p[30] ? (Q30_ONE - f) : f)};
    endfunction

    // configuration registers
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'd256;
            grid_reg   <= 9'd16;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                ADDR_RAD: radius_reg <= pwdata[15:0];
                ADDR_RES: grid_reg   <= pwdata[RES_W-1:0];
                default:  radius_reg <= radius_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == ADDR_RES) ? {23'd0, grid_reg} : {16'd0, radius_reg};

    always_comb
    begin
        priority if (grid_reg == '0)
            res_eff = RES_W'(1);
        else if (grid_reg > RES_W'(RES_MAX))
            res_eff = RES_W'(RES_MAX);
        else
            res_eff = grid_reg;
    end

    assign half_res = res_eff[8:1];

    // cell sequencer
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = item_valid_reg && !(en && (k_reg == K_LAST));
    assign accept   = in_valid && !in_stall;

    assign i_next = ({1'b0, lon_index} >= res_eff) ? 8'(res_eff - 1'b1) : lon_index;
    assign j_next = ({1'b0, lat_index} >= res_eff) ? 8'(res_eff - 1'b1) : lat_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            k_reg          <= '0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
            k_reg          <= '0;
        end
        else if (en && item_valid_reg)
        begin
            if (k_reg == K_LAST)
            begin
                item_valid_reg <= 1'b0;
            end
            else
            begin
                k_reg <= k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    // divider chain
    assign corner_a = {1'b0, i_reg} + RES_W'(DA_MASK[k_reg]);
    assign corner_b = {1'b0, j_reg} + RES_W'(DB_MASK[k_reg]);

    always_comb
    begin
        div_chain[0]         = '0;
        div_chain[0].valid   = item_valid_reg;
        div_chain[0].last    = (k_reg == K_LAST);
        div_chain[0].word[0] = {corner_a, 24'd0, half_res};
        div_chain[0].word[1] = {1'b0, corner_b, 23'd0, half_res};
        div_chain[0].word[2] = {17'd0, corner_a, 7'd0, half_res};
        div_chain[0].word[3] = {17'd0, corner_b, 7'd0, half_res};
    end

    for (genvar s = 0; s < DIV_W; s++)
    begin : g_div
        uvs_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .res       (res_eff),
            .stage_in  (div_chain[s]),
            .stage_out (div_chain[s+1])
        );
    end

    // fold phases into quarter-wave arguments
    assign fold[L_COSLON] = fold_phase(div_chain[DIV_W].word[0][31:0] + 32'h4000_0000);
    assign fold[L_SINLON] = fold_phase(div_chain[DIV_W].word[0][31:0]);
    assign fold[L_COSLAT] = fold_phase(div_chain[DIV_W].word[1][31:0] + 32'h4000_0000);
    assign fold[L_SINLAT] = fold_phase(div_chain[DIV_W].word[1][31:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg <= '0;
        end
        else if (en)
        begin
            prep_reg.valid <= div_chain[DIV_W].valid;
            prep_reg.last  <= div_chain[DIV_W].last;
            prep_reg.tex_u <= div_chain[DIV_W].word[2][15:0];
            prep_reg.tex_v <= div_chain[DIV_W].word[3][15:0];
            prep_reg.neg   <= {fold[L_SINLAT][Q30_W],
                               fold[L_COSLAT][Q30_W],
                               fold[L_SINLON][Q30_W],
                               fold[L_COSLON][Q30_W]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_reg[L_COSLON] <= fold[L_COSLON][Q30_W-1:0];
            arg_reg[L_SINLON] <= fold[L_SINLON][Q30_W-1:0];
            arg_reg[L_COSLAT] <= fold[L_COSLAT][Q30_W-1:0];
            arg_reg[L_SINLAT] <= fold[L_SINLAT][Q30_W-1:0];
        end
    end

    // sine lanes and matching sideband delay
    for (genvar l = 0; l < DIV_LANES; l++)
    begin : g_sine
        uvs_quarter_sine u_sine (
            .clk  (clk),
            .en   (en),
            .arg  (arg_reg[l]),
            .sine (sine[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SINE_LAT; s++)
            begin
                side_reg[s] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0] <= prep_reg;
            for (int s = 1; s < SINE_LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    // sine products
    assign mx_prod = 62'(sine[L_COSLON]) * 62'(sine[L_SINLAT]) + 62'(Q30_ONE >> 1);
    assign my_prod = 62'(sine[L_SINLON]) * 62'(sine[L_SINLAT]) + 62'(Q30_ONE >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_side_reg <= '0;
        end
        else if (en)
        begin
            p_side_reg.valid <= side_reg[SINE_LAT-1].valid;
            p_side_reg.last  <= side_reg[SINE_LAT-1].last;
            p_side_reg.tex_u <= side_reg[SINE_LAT-1].tex_u;
            p_side_reg.tex_v <= side_reg[SINE_LAT-1].tex_v;
            p_side_reg.neg   <= {1'b0,
                                 side_reg[SINE_LAT-1].neg[L_COSLAT],
                                 side_reg[SINE_LAT-1].neg[L_SINLON]
                                     ^ side_reg[SINE_LAT-1].neg[L_SINLAT],
                                 side_reg[SINE_LAT-1].neg[L_COSLON]
                                     ^ side_reg[SINE_LAT-1].neg[L_SINLAT]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg <= mx_prod[60:30];
            my_reg <= my_prod[60:30];
            mz_reg <= sine[L_COSLAT];
        end
    end

    // scale by radius
    assign vx_prod = 47'(radius_reg) * 47'(mx_reg) + 47'(Q30_ONE >> 1);
    assign vy_prod = 47'(radius_reg) * 47'(my_reg) + 47'(Q30_ONE >> 1);
    assign vz_prod = 47'(radius_reg) * 47'(mz_reg) + 47'(Q30_ONE >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_side_reg <= '0;
        end
        else if (en)
        begin
            c_side_reg <= p_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx_reg <= vx_prod[46:30];
            vy_reg <= vy_prod[46:30];
            vz_reg <= vz_prod[46:30];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_side_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x_reg <= c_side_reg.neg[0] ? 17'(-vx_reg) : vx_reg;
            pos_y_reg <= c_side_reg.neg[1] ? 17'(-vy_reg) : vy_reg;
            pos_z_reg <= c_side_reg.neg[2] ? 17'(-vz_reg) : vz_reg;
            tex_u_reg <= c_side_reg.tex_u;
            tex_v_reg <= c_side_reg.tex_v;
            last_reg  <= c_side_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign tex_u       = tex_u_reg;
    assign tex_v       = tex_v_reg;
    assign last_vertex = last_reg;

endmodule

/* hw/rtl/uvs_div_cell.sv */
// One restoring-division step for the four phase and texture quotients.
// Depends on uvs_pkg; chained 41 deep in the top level.
module uvs_div_cell
    import uvs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [RES_W-1:0] res,
    input  div_stage_t       stage_in,
    output div_stage_t       stage_out
);

    div_stage_t stage_reg;
    div_stage_t stage_next;

    always_comb
    begin
        logic [REM_W:0] t;
        stage_next       = stage_in;
        for (int l = 0; l < DIV_LANES; l++)
        begin
            t = {stage_in.rem[l], stage_in.word[l][DIV_W-1]};
            if (t >= res)
            begin
                stage_next.rem[l]  = REM_W'(t - res);
                stage_next.word[l] = {stage_in.word[l][DIV_W-2:0], 1'b1};
            end
            else
            begin
                stage_next.rem[l]  = t[REM_W-1:0];
                stage_next.word[l] = {stage_in.word[l][DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

/* hw/rtl/uvs_horner_cell.sv */
// One Horner step of the quarter-wave sine series, two register stages.
// Depends on uvs_pkg; six of these sit in each uvs_quarter_sine.
module uvs_horner_cell
    import uvs_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [RCP_W-1:0] rcp,
    input  logic [Q30_W-1:0] x_in,
    input  logic [31:0]      x2_in,
    input  logic [Q30_W-1:0] t_in,
    output logic [Q30_W-1:0] x_out,
    output logic [31:0]      x2_out,
    output logic [Q30_W-1:0] t_out
);

    logic [62:0]      prod_a;
    logic [69:0]      prod_b;
    logic [31:0]      p_reg;
    logic [Q30_W-1:0] xa_reg;
    logic [31:0]      x2a_reg;
    logic [Q30_W-1:0] x_reg;
    logic [31:0]      x2_reg;
    logic [Q30_W-1:0] t_reg;
    logic [Q30_W-1:0] t_next;

    assign prod_a = 63'(x2_in) * 63'(t_in);
    assign prod_b = 70'(p_reg) * 70'(rcp);
    assign t_next = Q30_ONE - Q30_W'(prod_b >> RCP_SHIFT);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg   <= prod_a[61:30];
            xa_reg  <= x_in;
            x2a_reg <= x2_in;
            t_reg   <= t_next;
            x_reg   <= xa_reg;
            x2_reg  <= x2a_reg;
        end
    end

    assign x_out  = x_reg;
    assign x2_out = x2_reg;
    assign t_out  = t_reg;

endmodule

/* hw/rtl/uvs_quarter_sine.sv */
// Quarter-wave sine in Q30: angle scale, square, six Horner cells, final round.
// Depends on uvs_pkg and uvs_horner_cell.
module uvs_quarter_sine
    import uvs_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [Q30_W-1:0] arg,
    output logic [Q30_W-1:0] sine
);

    logic [61:0]      x_prod;
    logic [61:0]      x2_prod;
    logic [62:0]      s_prod;
    logic [32:0]      s_round;
    logic [Q30_W-1:0] x_reg;
    logic [Q30_W-1:0] xs_reg;
    logic [31:0]      x2_reg;
    logic [Q30_W-1:0] s_reg;
    logic [Q30_W-1:0] hx  [HORNER_N+1];
    logic [31:0]      hx2 [HORNER_N+1];
    logic [Q30_W-1:0] ht  [HORNER_N+1];

    assign x_prod  = 62'(arg) * 62'(HALF_PI_Q30);
    assign x2_prod = 62'(x_reg) * 62'(x_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_prod[60:30];
            xs_reg <= x_reg;
            x2_reg <= x2_prod[61:30];
        end
    end

    assign hx[0]  = xs_reg;
    assign hx2[0] = x2_reg;
    assign ht[0]  = Q30_ONE;

    for (genvar k = 0; k < HORNER_N; k++)
    begin : g_horner
        uvs_horner_cell u_cell (
            .clk    (clk),
            .en     (en),
            .rcp    (HORNER_RCP[k]),
            .x_in   (hx[k]),
            .x2_in  (hx2[k]),
            .t_in   (ht[k]),
            .x_out  (hx[k+1]),
            .x2_out (hx2[k+1]),
            .t_out  (ht[k+1])
        );
    end

    assign s_prod  = 63'(hx[HORNER_N]) * 63'(ht[HORNER_N]) + 63'(Q30_ONE >> 1);
    assign s_round = s_prod[62:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= (s_round > 33'(Q30_ONE)) ? Q30_ONE : s_round[Q30_W-1:0];
        end
    end

    assign sine = s_reg;

endmodule

/* test/uv_sphere_cell_vertex_generator_tb.sv */
// Testbench for the UV-sphere cell vertex generator: random and directed cells,
// APB register phases, fixed-point sphere predictor. Depends on uvs_pkg and the RTL.
`timescale 1ns / 1ps

module uv_sphere_cell_vertex_generator_tb
    import uvs_pkg::*;
();

    localparam logic [2:0] ADDR_RADIUS = 3'd0;
    localparam logic [2:0] ADDR_RES    = 3'd4;
    localparam int WATCHDOG_LIMIT      = 20000;

    typedef struct packed {
        logic [7:0] lon;
        logic [7:0] lat;
    } cell_t;

    typedef struct packed {
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
        logic [15:0] u;
        logic [15:0] v;
        logic        last;
    } vertex_t;

    typedef struct {
        longint unsigned mag;
        bit              neg;
    } trig_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  lon_index;
    logic [7:0]  lat_index;
    logic        out_valid;
    logic        out_stall;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
    logic        last_vertex;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cell_t   cell_queue[$];
    vertex_t vertex_queue[$];
    logic [15:0] radius_reg;
    logic [8:0]  res_reg;
    int  error_count;
    int  quiet_cycles;
    bit  in_burst;
    bit  out_burst;

    uv_sphere_cell_vertex_generator u_top (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint unsigned quarter_sine(longint unsigned f);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        x  = (f * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        for (int k = 6; k >= 1; k--)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / longint'((2 * k) * (2 * k + 1));
        s = (x * t + (64'd1 << 29)) >> 30;
        return (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
    endfunction

    function automatic trig_t phase_sin(logic [31:0] p);
        trig_t r;
        longint unsigned f;
        f = 64'(p[29:0]);
        r.mag = p[30] ? quarter_sine((64'd1 << 30) - f) : quarter_sine(f);
        r.neg = p[31];
        return r;
    endfunction

    function automatic trig_t trig_mul(trig_t a, trig_t b);
        trig_t r;
        r.mag = (a.mag * b.mag + (64'd1 << 29)) >> 30;
        r.neg = a.neg ^ b.neg;
        return r;
    endfunction

    function automatic logic [16:0] scale_coord(trig_t m);
        longint unsigned v;
        v = (longint'(radius_reg) * m.mag + (64'd1 << 29)) >> 30;
        if (m.neg && v != 0)
            v = -v;
        return v[16:0];
    endfunction

    function automatic vertex_t corner_vertex(int a, int b, int res, bit last);
        vertex_t vx;
        logic [31:0] plon;
        logic [31:0] plat;
        trig_t cl;
        trig_t sl;
        trig_t ca;
        trig_t sa;
        plon = 32'(((longint'(a) << 32) + res / 2) / res);
        plat = 32'(((longint'(b) << 31) + res / 2) / res);
        cl = phase_sin(plon + 32'h4000_0000);
        sl = phase_sin(plon);
        ca = phase_sin(plat + 32'h4000_0000);
        sa = phase_sin(plat);
        vx.x = scale_coord(trig_mul(cl, sa));
        vx.y = scale_coord(trig_mul(sl, sa));
        vx.z = scale_coord(ca);
        vx.u = 16'((a * 32768 + res / 2) / res);
        vx.v = 16'((b * 32768 + res / 2) / res);
        vx.last = last;
        return vx;
    endfunction

    task automatic predict_cell(cell_t c);
        int res;
        int i;
        int j;
        int da[6] = '{0, 1, 0, 0, 1, 1};
        int db[6] = '{0, 0, 1, 1, 0, 1};
        res = (res_reg == 0) ? 1 : ((res_reg > RES_MAX) ? RES_MAX : int'(res_reg));
        i = (c.lon >= res) ? res - 1 : int'(c.lon);
        j = (c.lat >= res) ? res - 1 : int'(c.lat);
        for (int k = 0; k < 6; k++)
            vertex_queue.push_back(corner_vertex(i + da[k], j + db[k], res, k == 5));
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            lon_index <= '0;
            lat_index <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                predict_cell('{lon: lon_index, lat: lat_index});
            if (cell_queue.size() > 0 && (in_burst || $urandom_range(99) >= 13))
            begin
                cell_t c;
                c = cell_queue.pop_front();
                in_valid  <= 1'b1;
                lon_index <= c.lon;
                lat_index <= c.lat;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (vertex_queue.size() == 0)
                    report_mismatch("vertex with none expected");
                else
                begin
                    vertex_t e;
                    e = vertex_queue.pop_front();
                    if (pos_x !== e.x)
                        report_mismatch($sformatf("pos_x %h exp %h", pos_x, e.x));
                    if (pos_y !== e.y)
                        report_mismatch($sformatf("pos_y %h exp %h", pos_y, e.y));
                    if (pos_z !== e.z)
                        report_mismatch($sformatf("pos_z %h exp %h", pos_z, e.z));
                    if (tex_u !== e.u)
                        report_mismatch($sformatf("tex_u %h exp %h", tex_u, e.u));
                    if (tex_v !== e.v)
                        report_mismatch($sformatf("tex_v %h exp %h", tex_v, e.v));
                    if (last_vertex !== e.last)
                        report_mismatch($sformatf("last_vertex %b exp %b",
                                                  last_vertex, e.last));
                end
            end
            out_stall <= !out_burst && ($urandom_range(99) < 13);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("uv_sphere_cell_vertex_generator_tb NOT OK");
            $finish;
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RADIUS)
            radius_reg = data[15:0];
        else if (addr == ADDR_RES)
            res_reg = data[8:0];
    endtask

    task automatic drain();
        while (cell_queue.size() > 0 || in_valid || vertex_queue.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic add_random(int n, int res);
        int lim;
        lim = (res < 1) ? 1 : ((res > 256) ? 256 : res);
        for (int k = 0; k < n; k++)
        begin
            cell_t c;
            if ($urandom_range(9) == 0)
            begin
                c.lon = 8'($urandom);
                c.lat = 8'($urandom);
            end
            else
            begin
                c.lon = 8'($urandom_range(lim - 1));
                c.lat = 8'($urandom_range(lim - 1));
            end
            cell_queue.push_back(c);
        end
    endtask

    initial
    begin
        int res_set[6] = '{256, 1, 0, 300, 7, 511};
        int rad_set[6] = '{65535, 0, 1, 40000, 777, 256};
        error_count = 0;
        quiet_cycles = 0;
        radius_reg = 16'd256;
        res_reg = 9'd16;
        in_burst = 1'b0;
        out_burst = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: corners, clamp, alternating bits
        cell_queue.push_back('{lon: 8'd0, lat: 8'd0});
        cell_queue.push_back('{lon: 8'd15, lat: 8'd15});
        cell_queue.push_back('{lon: 8'd255, lat: 8'd0});
        cell_queue.push_back('{lon: 8'd0, lat: 8'd255});
        cell_queue.push_back('{lon: 8'd170, lat: 8'd85});
        cell_queue.push_back('{lon: 8'd7, lat: 8'd8});
        drain();
        for (int s = 0; s < 6; s++)
        begin
            apb_write(ADDR_RADIUS, rad_set[s]);
            apb_write(ADDR_RES, res_set[s]);
            cell_queue.push_back('{lon: 8'd0, lat: 8'd0});
            cell_queue.push_back('{lon: 8'd255, lat: 8'd255});
            cell_queue.push_back('{lon: 8'd85, lat: 8'd170});
            in_burst = (s == 2);
            out_burst = (s == 2);
            add_random(15, res_set[s]);
            drain();
        end
        in_burst = 1'b0;
        out_burst = 1'b0;

        if (error_count == 0)
            $display("uv_sphere_cell_vertex_generator_tb OK");
        else
            $display("uv_sphere_cell_vertex_generator_tb NOT OK");
        $finish;
    end
endmodule
